>>> hdl/sha512_pkg.sv
package sha512_pkg;

	localparam int WordW = 64;
	localparam int Rounds = 80;
	localparam int RoundW = 7;
	localparam int BlockBytes = 128;
	localparam int PosW = 7;
	localparam int CountW = 61;
	localparam int LenPos = 112;

	// Work request passed from the front end to the compression engine
	typedef struct packed {
		logic [16*WordW-1:0] block;
		logic                final_blk;
	} blk_req_t;

	localparam logic [WordW-1:0] INIT_H [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [WordW-1:0] ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

endpackage

>>> hdl/sha512_front.sv
// Byte collector and padder: builds 128-byte blocks and issues them as requests
module sha512_front import sha512_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  logic           has_byte,
	input  logic           last,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           req_valid,
	input  logic           req_ready,
	output blk_req_t       req
);

	typedef enum logic [1:0] {ST_COLLECT, ST_PAD, ST_LEN} fstate_t;

	fstate_t               state_q;
	logic [WordW-1:0]      buf_q [16];
	logic [CountW-1:0]     count_q;
	logic [CountW-1:0]     len_q;
	logic                  req_valid_q;
	logic                  req_final_q;
	logic [16*WordW-1:0]   req_blk_q;
	logic                  out_free;
	logic [PosW-1:0]       pos;
	logic [PosW-1:0]       ppos;
	logic [PosW-1:0]       pad_pos;
	logic                  take;
	logic                  blk_full;
	logic                  req_load;
	logic [WordW-1:0]      merged [16];
	logic [WordW-1:0]      padded [16];
	logic [16*WordW-1:0]   merged_pk;
	logic [16*WordW-1:0]   buf_pk;
	logic [2*WordW-1:0]    bitlen;

	assign out_free  = !req_valid_q || req_ready;
	assign in_ready  = (state_q == ST_COLLECT) && out_free;
	assign take      = in_valid && in_ready;
	assign pos       = count_q[PosW-1:0];
	assign ppos      = pos + PosW'(1);
	assign pad_pos   = has_byte ? ppos : pos;
	assign blk_full  = has_byte && (pos == PosW'(BlockBytes-1));
	assign req_load  = ((state_q == ST_COLLECT) && take && blk_full)
		|| ((state_q != ST_COLLECT) && out_free);
	assign req_valid = req_valid_q;
	assign req.block = req_blk_q;
	assign req.final_blk = req_final_q;
	assign bitlen    = {64'd0, len_q, 3'd0};

	// Current buffer view with the incoming byte merged in, big-endian words
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			merged[w] = buf_q[w];
		end
		for (int i = 0; i < BlockBytes; i++) begin
			if (has_byte && pos == PosW'(i)) begin
				merged[i >> 3][(7 - (i & 7))*8 +: 8] = data_byte;
			end
		end
	end

	// Padding marker and zero fill after the last byte
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			padded[w] = merged[w];
		end
		for (int i = 0; i < BlockBytes; i++) begin
			if (PosW'(i) == pad_pos) begin
				padded[i >> 3][(7 - (i & 7))*8 +: 8] = 8'h80;
			end else if (PosW'(i) > pad_pos) begin
				padded[i >> 3][(7 - (i & 7))*8 +: 8] = 8'h00;
			end
		end
	end

	// Word 0 in the top bits
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			merged_pk[(15-w)*WordW +: WordW] = merged[w];
			buf_pk[(15-w)*WordW +: WordW]    = buf_q[w];
		end
	end

	// Collect, pad and hand blocks to the queue register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			count_q     <= '0;
			req_valid_q <= 1'b0;
			req_final_q <= 1'b0;
		end else begin
			if (req_load) begin
				req_valid_q <= 1'b1;
			end else if (req_valid_q && req_ready) begin
				req_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (take) begin
						if (blk_full) begin
							req_blk_q   <= merged_pk;
							req_final_q <= 1'b0;
						end
						if (last) begin
							len_q   <= count_q + CountW'(has_byte);
							count_q <= '0;
							if (blk_full) begin
								// Full block goes now, padding starts on a fresh one
								for (int w = 0; w < 16; w++) begin
									if (w == 0) begin
										buf_q[w] <= {8'h80, 56'd0};
									end else begin
										buf_q[w] <= '0;
									end
								end
								state_q <= ST_LEN;
							end else begin
								for (int w = 0; w < 16; w++) begin
									buf_q[w] <= padded[w];
								end
								state_q <= (pad_pos >= PosW'(LenPos)) ? ST_PAD : ST_LEN;
							end
						end else begin
							for (int w = 0; w < 16; w++) begin
								buf_q[w] <= merged[w];
							end
							if (has_byte) begin
								count_q <= count_q + CountW'(1);
							end
						end
					end
				end
				ST_PAD: begin
					if (out_free) begin
						req_blk_q   <= buf_pk;
						req_final_q <= 1'b0;
						for (int w = 0; w < 16; w++) begin
							buf_q[w] <= '0;
						end
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (out_free) begin
						req_blk_q   <= {buf_pk[16*WordW-1:2*WordW], bitlen};
						req_final_q <= 1'b1;
						state_q     <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> !in_ready)
		else $error("input taken while padding");
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid_q && !req_ready) |=> req_valid_q)
		else $error("block request dropped");
	a_len_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN && out_free) |=> (req_valid_q && req_final_q))
		else $error("final block not issued");
`endif

endmodule

>>> hdl/sha512_core.sv
// Compression engine: one round per cycle, 16-word rolling schedule
module sha512_core import sha512_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  blk_req_t             req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [8*WordW-1:0]   out_digest
);

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD} cstate_t;

	cstate_t             state_q;
	logic [WordW-1:0]    h_q [8];
	logic [WordW-1:0]    r_q [8];
	logic [WordW-1:0]    w_q [16];
	logic [RoundW-1:0]   rnd_q;
	logic                final_q;
	logic                out_valid_q;
	logic [8*WordW-1:0]  dig_q;
	logic                dig_load;
	logic [WordW-1:0]    w_new, s0, s1, t1, t2, ch, maj, e_sig, a_sig;

	assign req_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_digest = dig_q;
	// Final add waits until the digest register is free
	assign dig_load   = (state_q == ST_ADD) && final_q && (!out_valid_q || out_ready);

	// Round datapath
	always_comb begin
		s0    = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
		s1    = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		e_sig = rotr(r_q[4], 14) ^ rotr(r_q[4], 18) ^ rotr(r_q[4], 41);
		ch    = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
		a_sig = rotr(r_q[0], 28) ^ rotr(r_q[0], 34) ^ rotr(r_q[0], 39);
		maj   = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
		t1    = r_q[7] + e_sig + ch + ROUND_K[rnd_q] + w_q[0];
		t2    = a_sig + maj;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
			final_q     <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else begin
			if (dig_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						for (int i = 0; i < 16; i++) begin
							w_q[i] <= req.block[(15-i)*WordW +: WordW];
						end
						for (int i = 0; i < 8; i++) begin
							r_q[i] <= h_q[i];
						end
						final_q <= req.final_blk;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i+1];
					end
					w_q[15] <= w_new;
					r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
					r_q[4] <= r_q[3] + t1;
					r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
					r_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + RoundW'(1);
					if (rnd_q == RoundW'(Rounds-1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!final_q) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= h_q[i] + r_q[i];
						end
						state_q <= ST_IDLE;
					end else if (dig_load) begin
						for (int i = 0; i < 8; i++) begin
							dig_q[(7-i)*WordW +: WordW] <= h_q[i] + r_q[i];
							h_q[i] <= INIT_H[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q < RoundW'(Rounds)))
		else $error("round counter out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(dig_q)))
		else $error("digest changed while stalled");
	a_add_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && (!final_q || dig_load)) |=> (state_q == ST_IDLE))
		else $error("add step sequencing");
`endif

endmodule

>>> hdl/sha512_hash.sv
// SHA-512 streaming hasher.
// Input channel s_axis: one request per message byte. tdata[7:0] is the byte,
// tuser[0] (has_byte) says whether tdata carries a byte, tlast ends the
// message. A last request with has_byte low finishes the message as it is,
// so an empty message is one request with tlast high and has_byte low.
// Output channel m_axis: one request per message, tdata holds the 512-bit
// digest, digest word 0 in the lowest 64 bits.
// The front end takes one byte per cycle; a full 128-byte block is queued
// to the compression engine, which loads it, runs 80 rounds at one per
// cycle and then adds the result to the hash, and the engine keeps up with
// one byte per cycle on long messages. The front end stalls while a queued
// block waits for the busy engine, and while it issues the padding blocks
// after the last request. Padding takes one or two blocks. A stalled
// receiver holds the digest; the engine then finishes the next final block
// and waits with it until the digest is taken.
// Reset loads the initial hash values and clears the byte count.
module sha512_hash import sha512_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [7:0]     s_axis_tdata,   // [7:0] data_byte
	input  logic           s_axis_tuser,   // [0] has_byte
	input  logic           s_axis_tlast,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [511:0]   m_axis_tdata    // digest_word_0 .. digest_word_7, 64 bits each
);

	blk_req_t            req;
	logic                req_valid;
	logic                req_ready;
	logic [8*WordW-1:0]  dig;

	sha512_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_axis_tdata),
		.has_byte  (s_axis_tuser),
		.last      (s_axis_tlast),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	sha512_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_digest (dig)
	);

	// Word 0 goes to the low bits
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			m_axis_tdata[i*WordW +: WordW] = dig[(7-i)*WordW +: WordW];
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sha512_pkg::*;

	typedef logic [63:0] word_t;

	// Scoreboard: SHA-512 predictor plus a queue of pending digests
	class digest_board;
		word_t h [8];
		logic [7:0] blk [128];
		logic [60:0] nbytes;
		logic [511:0] pending [$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) h[i] = INIT_H[i];
			nbytes = '0;
		endfunction

		function word_t ror(word_t x, int n);
			return (x >> n) | (x << (64 - n));
		endfunction

		function void compress();
			word_t w [16];
			word_t r [8];
			word_t wt, t1, t2, x0, x1;
			for (int i = 0; i < 16; i++) begin
				wt = '0;
				for (int j = 0; j < 8; j++) wt = {wt[55:0], blk[i*8+j]};
				w[i] = wt;
			end
			for (int i = 0; i < 8; i++) r[i] = h[i];
			for (int i = 0; i < 80; i++) begin
				if (i < 16) begin
					wt = w[i];
				end else begin
					x0 = w[(i-15) & 15];
					x1 = w[(i-2) & 15];
					wt = (ror(x1,19) ^ ror(x1,61) ^ (x1 >> 6)) + w[(i-7) & 15]
						+ (ror(x0,1) ^ ror(x0,8) ^ (x0 >> 7)) + w[i & 15];
					w[i & 15] = wt;
				end
				t1 = r[7] + (ror(r[4],14) ^ ror(r[4],18) ^ ror(r[4],41))
					+ ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + wt;
				t2 = (ror(r[0],28) ^ ror(r[0],34) ^ ror(r[0],39))
					+ ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
				r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
				r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) h[i] += r[i];
		endfunction

		// note an accepted request
		function void note_request(logic [7:0] b, logic has_b, logic lst);
			int pos;
			word_t bits;
			logic [511:0] d;
			if (has_b) begin
				pos = int'(nbytes[6:0]);
				blk[pos] = b;
				nbytes++;
				if (pos == 127) compress();
			end
			if (!lst) return;
			pos = int'(nbytes[6:0]);
			blk[pos] = 8'h80;
			for (int i = pos + 1; i < 128; i++) blk[i] = '0;
			if (pos >= LenPos) begin
				compress();
				for (int i = 0; i < 128; i++) blk[i] = '0;
			end
			bits = {nbytes, 3'b000};
			for (int i = 0; i < 8; i++) blk[120+i] = bits[63-8*i -: 8];
			compress();
			for (int i = 0; i < 8; i++) d[64*i +: 64] = h[i];
			pending = {pending, d};
			restart();
		endfunction

		// check one digest from the block
		task check_digest(logic [511:0] got);
			logic [511:0] exp_d;
			if (pending.size() == 0) begin
				report("digest with none expected");
				return;
			end
			exp_d = pending.pop_front();
			for (int i = 0; i < 8; i++)
				if (got[64*i +: 64] !== exp_d[64*i +: 64])
					report($sformatf("digest_word_%0d got %h exp %h", i,
						got[64*i +: 64], exp_d[64*i +: 64]));
		endtask

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [511:0] m_axis_tdata;

	digest_board sb = new();
	bit no_idle = 0;
	bit hold_rx = 0;
	int stall_cnt = 0;

	sha512_hash uut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// one request; holds tvalid across back-to-back sends
	task automatic send(logic [7:0] b, logic hb, logic lst);
		int gap;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= hb;
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(b, hb, lst);
	endtask

	task automatic send_msg(int len);
		for (int i = 0; i < len; i++)
			send(8'($urandom_range(0, 255)), 1'b1, (i == len - 1));
		if (len == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_rx = 0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// output monitor
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_digest(m_axis_tdata);

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, byte without last, extremes, padding edges
		send(8'h00, 1'b0, 1'b1);
		send(8'hff, 1'b0, 1'b0);
		send(8'h00, 1'b1, 1'b0);
		send(8'hff, 1'b0, 1'b0);
		send(8'hff, 1'b1, 1'b1);
		send(8'h5a, 1'b1, 1'b0);
		send(8'ha5, 1'b0, 1'b1);
		send_msg(3);
		drain();
		send_msg(111);
		send_msg(112);
		send_msg(127);
		send_msg(128);
		send_msg(129);
		send_msg(256);

		// sender pause until all digests are back
		drain();

		// long receiver hold-off while short messages keep coming
		hold_rx = 1;
		for (int i = 0; i < 12; i++) send_msg($urandom_range(0, 4));
		drain();

		// random messages, mostly short, some with idle/no-op requests
		sent = 0;
		while (sent < 300) begin
			if (sent > 200) no_idle = 1;
			case ($urandom_range(0, 9))
				0: len = $urandom_range(100, 260);
				1: len = 0;
				default: len = $urandom_range(1, 20);
			endcase
			if ($urandom_range(0, 4) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_msg(len);
			sent += (len == 0) ? 1 : len;
		end
		drain();
		repeat (300) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
